>>> sv/ajc_pkg.sv
`timescale 1ns / 1ps
// Package for the admittance joint controller: configuration bundle, register
// indexes, fixed-point constants and the command/status structs of the sequencer.
// No dependencies.
package ajc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_IDX_INV_MASS  = 3'd0;
    localparam logic [2:0] CFG_IDX_DAMPING   = 3'd1;
    localparam logic [2:0] CFG_IDX_STIFFNESS = 3'd2;
    localparam logic [2:0] CFG_IDX_PROP      = 3'd3;
    localparam logic [2:0] CFG_IDX_DERIV     = 3'd4;
    localparam logic [2:0] CFG_IDX_EQ_ANGLE  = 3'd5;
    localparam logic [2:0] CFG_IDX_DEV_LIMIT = 3'd6;
    localparam logic [2:0] CFG_IDX_TRQ_LIMIT = 3'd7;

    // Configuration reset values.
    localparam logic [15:0]        RST_INV_MASS  = 16'd512;
    localparam logic [15:0]        RST_DAMPING   = 16'd512;
    localparam logic [15:0]        RST_STIFFNESS = 16'd1280;
    localparam logic [15:0]        RST_PROP      = 16'd77;
    localparam logic [15:0]        RST_DERIV     = 16'd655;
    localparam logic signed [15:0] RST_EQ_ANGLE  = 16'sd0;
    localparam logic [14:0]        RST_DEV_LIMIT = 15'd2560;
    localparam logic [14:0]        RST_TRQ_LIMIT = 15'd1280;

    // Fixed-point scale factors.
    // Degrees to radians, Q24.
    localparam logic signed [19:0] K_DEG_TO_RAD = 20'sd292817;
    // Radians to degrees times the 1 ms tick, Q24.
    localparam logic signed [20:0] K_RAD_TO_DEG_DT = 21'sd961264;
    // The 1 ms tick, Q32.
    localparam logic signed [23:0] K_DT = 24'sd4294967;
    // Speed term scale of the PD law.
    localparam logic signed [10:0] K_SPEED = 11'sd1000;
    // Acceleration bound of plus or minus 2^40.
    localparam logic signed [47:0] ACC_MAX = 48'sh0100_0000_0000;
    localparam logic signed [47:0] ACC_MIN = -48'sh0100_0000_0000;
    // 32-bit signed velocity range.
    localparam logic signed [39:0] VEL_MAX = 40'sh00_7FFF_FFFF;
    localparam logic signed [39:0] VEL_MIN = -40'sh00_8000_0000;
    // 16-bit signed angle range.
    localparam logic signed [16:0] ANG_MAX = 17'sd32767;
    localparam logic signed [16:0] ANG_MIN = -17'sd32768;

    // Configuration bundle.
    typedef struct packed {
        logic [15:0]        inverse_mass;
        logic [15:0]        damping_gain;
        logic [15:0]        stiffness_gain;
        logic [15:0]        prop_gain;
        logic [15:0]        deriv_gain;
        logic signed [15:0] equilibrium_angle;
        logic [14:0]        deviation_limit;
        logic [14:0]        torque_limit;
    } t_cfg;

    // One strobe per datapath step, issued by the sequencer.
    typedef struct packed {
        logic load;
        logic rad;
        logic frc;
        logic sum;
        logic acc;
        logic vel;
        logic vupd;
        logic posm;
        logic pupd;
        logic refc;
        logic pd1;
        logic pd2;
        logic raw;
        logic out;
    } t_cmd;

    // Datapath status toward the sequencer.
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

>>> sv/ajc_in_if.sv
`timescale 1ns / 1ps
// Input channel of the admittance joint controller: valid/ready handshake
// carrying one sensor beat. No dependencies.
interface ajc_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] ext_torque;
    logic signed [15:0] joint_angle;

    modport source (output valid, action, ext_torque, joint_angle, input ready);
    modport sink   (input valid, action, ext_torque, joint_angle, output ready);
endinterface

>>> sv/ajc_out_if.sv
`timescale 1ns / 1ps
// Output channel of the admittance joint controller: valid/ready handshake
// carrying one result beat. No dependencies.
interface ajc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_torque;
    logic signed [15:0] deviation;
    logic signed [15:0] reference_angle;
    logic               torque_saturated;

    modport source (output valid, drive_torque, deviation, reference_angle,
                    torque_saturated, input ready);
    modport sink   (input valid, drive_torque, deviation, reference_angle,
                    torque_saturated, output ready);
endinterface

>>> sv/admittance_joint_controller_top.sv
`timescale 1ns / 1ps
// Admittance joint controller top level: one joint's mass-spring-damper and PD loop.
// A new input beat is accepted only in idle, after the sequencer has stepped the last
// update through its thirteen datapath steps; a stalled output holds it in the last step.
// Reset: synchronous, active low; configuration registers return to their defaults, state is zero.
// Depends on ajc_pkg, ajc_in_if, ajc_out_if, ajc_cfg, ajc_ctrl, ajc_datapath.
module admittance_joint_controller_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ajc_in_if.sink       i_in,
    ajc_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);

    ajc_pkg::t_cfg  cfg;
    ajc_pkg::t_cmd  cmd;
    ajc_pkg::t_stat stat;
    logic           in_ready;

    // Configuration registers.
    ajc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Sequencer.
    ajc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Datapath and output register.
    ajc_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg              (cfg),
        .i_action           (i_in.action),
        .i_ext_torque       (i_in.ext_torque),
        .i_joint_angle      (i_in.joint_angle),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_drive_torque     (o_out.drive_torque),
        .o_deviation        (o_out.deviation),
        .o_reference_angle  (o_out.reference_angle),
        .o_torque_saturated (o_out.torque_saturated)
    );

endmodule

>>> sv/ajc_cfg.sv
`timescale 1ns / 1ps
// Configuration register bank of the admittance joint controller.
// Depends on ajc_pkg.
module ajc_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    output ajc_pkg::t_cfg  o_cfg
);

    ajc_pkg::t_cfg r_cfg;

    // Register writes; each register keeps only its own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inverse_mass      <= ajc_pkg::RST_INV_MASS;
            r_cfg.damping_gain      <= ajc_pkg::RST_DAMPING;
            r_cfg.stiffness_gain    <= ajc_pkg::RST_STIFFNESS;
            r_cfg.prop_gain         <= ajc_pkg::RST_PROP;
            r_cfg.deriv_gain        <= ajc_pkg::RST_DERIV;
            r_cfg.equilibrium_angle <= ajc_pkg::RST_EQ_ANGLE;
            r_cfg.deviation_limit   <= ajc_pkg::RST_DEV_LIMIT;
            r_cfg.torque_limit      <= ajc_pkg::RST_TRQ_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ajc_pkg::CFG_IDX_INV_MASS:  r_cfg.inverse_mass      <= i_cfg_data;
                ajc_pkg::CFG_IDX_DAMPING:   r_cfg.damping_gain      <= i_cfg_data;
                ajc_pkg::CFG_IDX_STIFFNESS: r_cfg.stiffness_gain    <= i_cfg_data;
                ajc_pkg::CFG_IDX_PROP:      r_cfg.prop_gain         <= i_cfg_data;
                ajc_pkg::CFG_IDX_DERIV:     r_cfg.deriv_gain        <= i_cfg_data;
                ajc_pkg::CFG_IDX_EQ_ANGLE:  r_cfg.equilibrium_angle <= $signed(i_cfg_data);
                ajc_pkg::CFG_IDX_DEV_LIMIT: r_cfg.deviation_limit   <= i_cfg_data[14:0];
                ajc_pkg::CFG_IDX_TRQ_LIMIT: r_cfg.torque_limit      <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/ajc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the admittance joint controller: one-hot state machine that
// steps the datapath through one update. Depends on ajc_pkg.
module ajc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ajc_pkg::t_stat  i_stat,
    output ajc_pkg::t_cmd   o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE = 14'h0001,
        S_RAD  = 14'h0002,
        S_FRC  = 14'h0004,
        S_SUM  = 14'h0008,
        S_ACC  = 14'h0010,
        S_VEL  = 14'h0020,
        S_VUPD = 14'h0040,
        S_POSM = 14'h0080,
        S_PUPD = 14'h0100,
        S_REF  = 14'h0200,
        S_PD1  = 14'h0400,
        S_PD2  = 14'h0800,
        S_RAW  = 14'h1000,
        S_OUT  = 14'h2000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and step strobes.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RAD;
                end
            end
            S_RAD: begin
                o_cmd.rad = 1'b1;
                n_state   = S_FRC;
            end
            S_FRC: begin
                o_cmd.frc = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_VEL;
            end
            S_VEL: begin
                o_cmd.vel = 1'b1;
                n_state   = S_VUPD;
            end
            S_VUPD: begin
                o_cmd.vupd = 1'b1;
                n_state    = S_POSM;
            end
            S_POSM: begin
                o_cmd.posm = 1'b1;
                n_state    = S_PUPD;
            end
            S_PUPD: begin
                o_cmd.pupd = 1'b1;
                n_state    = S_REF;
            end
            S_REF: begin
                o_cmd.refc = 1'b1;
                n_state    = S_PD1;
            end
            S_PD1: begin
                o_cmd.pd1 = 1'b1;
                n_state   = S_PD2;
            end
            S_PD2: begin
                o_cmd.pd2 = 1'b1;
                n_state   = S_RAW;
            end
            S_RAW: begin
                o_cmd.raw = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // Hold here until the output register can take the new beat.
                if (i_stat.out_free) begin
                    o_cmd.out = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/ajc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the admittance joint controller: admittance state, the
// fixed-point steps of one update and the output register. Depends on ajc_pkg.
module ajc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ajc_pkg::t_cmd      i_cmd,
    output ajc_pkg::t_stat     o_stat,
    input  ajc_pkg::t_cfg      i_cfg,
    input  logic               i_action,
    input  logic signed [15:0] i_ext_torque,
    input  logic signed [15:0] i_joint_angle,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_drive_torque,
    output logic signed [15:0] o_deviation,
    output logic signed [15:0] o_reference_angle,
    output logic               o_torque_saturated
);

    // Admittance state.
    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic signed [15:0] r_last;

    // Latched input beat.
    logic signed [15:0] r_tau;
    logic signed [15:0] r_ang;

    // Intermediate results of the steps.
    logic signed [51:0] r_prod_p;
    logic signed [51:0] r_prod_v;
    logic signed [44:0] r_fp;
    logic signed [44:0] r_fv;
    logic signed [46:0] r_force;
    logic signed [55:0] r_accp;
    logic signed [62:0] r_vp;
    logic signed [55:0] r_pp;
    logic signed [15:0] r_ref;
    logic signed [33:0] r_pe;
    logic signed [33:0] r_dd;
    logic signed [44:0] r_dd1k;
    logic signed [30:0] r_raw;

    // Output register.
    logic               r_ovalid;
    logic signed [15:0] r_odrive;
    logic signed [15:0] r_odev;
    logic signed [15:0] r_oref;
    logic               r_osat;

    // Gains as signed operands.
    logic signed [16:0] inv_s;
    logic signed [16:0] damp_s;
    logic signed [16:0] stiff_s;
    logic signed [16:0] prop_s;
    logic signed [16:0] deriv_s;

    logic signed [27:0] pos_rad;
    logic signed [27:0] vel_rad;
    logic signed [31:0] tau_sh;
    logic signed [47:0] acc_full;
    logic signed [41:0] acc_c;
    logic signed [39:0] vel_sum;
    logic signed [31:0] vel_new;
    logic signed [32:0] pos_sum;
    logic signed [32:0] plim;
    logic signed [31:0] pos_new;
    logic signed [15:0] dev;
    logic signed [16:0] ref_sum;
    logic signed [15:0] ref_new;
    logic signed [16:0] err;
    logic signed [16:0] diff;
    logic signed [45:0] raw_full;
    logic signed [30:0] tlim;
    logic signed [15:0] drive_new;
    logic               sat_new;
    logic               out_free;

    assign inv_s   = $signed({1'b0, i_cfg.inverse_mass});
    assign damp_s  = $signed({1'b0, i_cfg.damping_gain});
    assign stiff_s = $signed({1'b0, i_cfg.stiffness_gain});
    assign prop_s  = $signed({1'b0, i_cfg.prop_gain});
    assign deriv_s = $signed({1'b0, i_cfg.deriv_gain});

    // Floor shifts are taken as part-selects of the signed products.
    assign pos_rad  = $signed(r_prod_p[51:24]);
    assign vel_rad  = $signed(r_prod_v[51:24]);
    assign tau_sh   = $signed({r_tau, 16'h0000});
    assign acc_full = $signed(r_accp[55:8]);

    // Acceleration bounded to plus or minus 2^40.
    always_comb begin
        if (acc_full > ajc_pkg::ACC_MAX) begin
            acc_c = ajc_pkg::ACC_MAX[41:0];
        end else if (acc_full < ajc_pkg::ACC_MIN) begin
            acc_c = ajc_pkg::ACC_MIN[41:0];
        end else begin
            acc_c = acc_full[41:0];
        end
    end

    // Velocity update, saturated to 32 bits.
    assign vel_sum = 40'(r_vel) + 40'($signed(r_vp[62:24]));
    always_comb begin
        if (vel_sum > ajc_pkg::VEL_MAX) begin
            vel_new = ajc_pkg::VEL_MAX[31:0];
        end else if (vel_sum < ajc_pkg::VEL_MIN) begin
            vel_new = ajc_pkg::VEL_MIN[31:0];
        end else begin
            vel_new = vel_sum[31:0];
        end
    end

    // Position update, clamped to the deviation limit scaled by 2^9.
    assign pos_sum = 33'(r_pos) + 33'($signed(r_pp[55:32]));
    assign plim    = $signed({9'h000, i_cfg.deviation_limit, 9'h000});
    always_comb begin
        if (pos_sum > plim) begin
            pos_new = plim[31:0];
        end else if (pos_sum < -plim) begin
            pos_new = 32'(-plim);
        end else begin
            pos_new = pos_sum[31:0];
        end
    end

    // The stored deviation stays below 2^24 in magnitude, so bits 24..9 hold
    // the floored angle deviation.
    assign dev     = $signed(r_pos[24:9]);
    assign ref_sum = 17'(dev) + 17'(i_cfg.equilibrium_angle);
    always_comb begin
        if (ref_sum > ajc_pkg::ANG_MAX) begin
            ref_new = ajc_pkg::ANG_MAX[15:0];
        end else if (ref_sum < ajc_pkg::ANG_MIN) begin
            ref_new = ajc_pkg::ANG_MIN[15:0];
        end else begin
            ref_new = ref_sum[15:0];
        end
    end

    assign err  = 17'(r_ref) - 17'(r_ang);
    assign diff = 17'(r_ang) - 17'(r_last);

    // PD sum and torque saturation.
    assign raw_full = 46'($signed({r_pe, 8'h00})) - 46'(r_dd1k);
    assign tlim     = $signed({16'h0000, i_cfg.torque_limit});
    always_comb begin
        if (r_raw > tlim) begin
            drive_new = tlim[15:0];
            sat_new   = 1'b1;
        end else if (r_raw < -tlim) begin
            drive_new = 16'(-tlim);
            sat_new   = 1'b1;
        end else begin
            drive_new = r_raw[15:0];
            sat_new   = 1'b0;
        end
    end

    assign out_free        = !r_ovalid || i_out_ready;
    assign o_stat.out_free = out_free;

    // Admittance state; a reset action clears it and loads the previous-angle register with the input angle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_vel  <= '0;
            r_last <= '0;
        end else begin
            if (i_cmd.load && i_action) begin
                r_pos  <= '0;
                r_vel  <= '0;
                r_last <= i_joint_angle;
            end
            if (i_cmd.vupd) begin
                r_vel <= vel_new;
            end
            if (i_cmd.pupd) begin
                r_pos <= pos_new;
            end
            if (i_cmd.pd1) begin
                r_last <= r_ang;
            end
        end
    end

    // Step registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tau <= i_ext_torque;
            r_ang <= i_joint_angle;
        end
        if (i_cmd.rad) begin
            r_prod_p <= 52'(r_pos) * 52'(ajc_pkg::K_DEG_TO_RAD);
            r_prod_v <= 52'(r_vel) * 52'(ajc_pkg::K_DEG_TO_RAD);
        end
        if (i_cmd.frc) begin
            r_fp <= 45'(pos_rad) * 45'(stiff_s);
            r_fv <= 45'(vel_rad) * 45'(damp_s);
        end
        if (i_cmd.sum) begin
            r_force <= 47'(tau_sh) - 47'(r_fp) - 47'(r_fv);
        end
        if (i_cmd.acc) begin
            r_accp <= 56'($signed(r_force[46:8])) * 56'(inv_s);
        end
        if (i_cmd.vel) begin
            r_vp <= 63'(acc_c) * 63'(ajc_pkg::K_RAD_TO_DEG_DT);
        end
        if (i_cmd.posm) begin
            r_pp <= 56'(r_vel) * 56'(ajc_pkg::K_DT);
        end
        if (i_cmd.refc) begin
            r_ref <= ref_new;
        end
        if (i_cmd.pd1) begin
            r_pe <= 34'(err) * 34'(prop_s);
            r_dd <= 34'(diff) * 34'(deriv_s);
        end
        if (i_cmd.pd2) begin
            r_dd1k <= 45'(r_dd) * 45'(ajc_pkg::K_SPEED);
        end
        if (i_cmd.raw) begin
            r_raw <= raw_full[45:15];
        end
    end

    // Output beat: a new result replaces the old one once it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out) begin
            r_odrive <= drive_new;
            r_odev   <= dev;
            r_oref   <= r_ref;
            r_osat   <= sat_new;
        end
    end

    assign o_out_valid        = r_ovalid;
    assign o_drive_torque     = r_odrive;
    assign o_deviation        = r_odev;
    assign o_reference_angle  = r_oref;
    assign o_torque_saturated = r_osat;

endmodule
